@@ design/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// shared constants for the quaternion vector rotator: control register map
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_QUAT_W = 2'd0;
   localparam csr_index_type CSR_QUAT_X = 2'd1;
   localparam csr_index_type CSR_QUAT_Y = 2'd2;
   localparam csr_index_type CSR_QUAT_Z = 2'd3;

endpackage

@@ design/qvr_req_if.sv @@
// ----------------------------------------------------------------------------
// qvr_req_if
// request channel: one input vector word with its last flag
// ----------------------------------------------------------------------------
interface qvr_req_if #(
   parameter int VEC_WIDTH = 24
);
   logic                        valid;
   logic                        ready;
   logic signed [VEC_WIDTH-1:0] in_x;
   logic signed [VEC_WIDTH-1:0] in_y;
   logic signed [VEC_WIDTH-1:0] in_z;
   logic                        in_last;

   modport source (output valid, output in_x, output in_y, output in_z, output in_last,
                   input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, input in_last,
                   output ready);
endinterface

@@ design/qvr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qvr_rsp_if
// response channel: one rotated vector word with its last flag
// ----------------------------------------------------------------------------
interface qvr_rsp_if #(
   parameter int VEC_WIDTH = 24
);
   logic                        valid;
   logic                        ready;
   logic signed [VEC_WIDTH-1:0] out_x;
   logic signed [VEC_WIDTH-1:0] out_y;
   logic signed [VEC_WIDTH-1:0] out_z;
   logic                        out_last;

   modport source (output valid, output out_x, output out_y, output out_z, output out_last,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_last,
                   output ready);
endinterface

@@ design/quaternion_vector_rotate.sv @@
// an accepted request word passes through stage registers s1, s2, s3 and s4 to its response word
// throughput: one word per cycle while the response side is ready, set by the four-stage multiply/sum pipeline
// stalls on the response side back up stage by stage; empty stages still fill
// reset: synchronous, active high; clears all stage valid bits and loads
// the quaternion with 1.0 + 0i + 0j + 0k
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates each vector p by q * p * conj(q), fixed point, rounded and saturated
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int VEC_WIDTH  = 24,
   parameter int QUAT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [QUAT_WIDTH-1:0]  csr_wdata,
   qvr_req_if.sink                req_if,
   qvr_rsp_if.source              rsp_if
);

   localparam int FRAC = QUAT_WIDTH - 2;
   localparam int PW   = VEC_WIDTH + QUAT_WIDTH;   // first product
   localparam int SW1  = PW + 1;                   // first sum
   localparam int TW   = VEC_WIDTH + 3;            // intermediate term
   localparam int MW   = TW + QUAT_WIDTH;          // second product
   localparam int SW2  = MW + 2;                   // second sum

   localparam logic signed [SW1-1:0] HALF1 = SW1'(1) <<< (FRAC - 1);
   localparam logic signed [SW2-1:0] HALF2 = SW2'(1) <<< (FRAC - 1);
   localparam logic signed [SW2-1:0] VMAX  = (SW2'(1) <<< (VEC_WIDTH - 1)) - SW2'(1);
   localparam logic signed [SW2-1:0] VMIN  = -(SW2'(1) <<< (VEC_WIDTH - 1));

   // quaternion registers, order w x y z
   logic signed [QUAT_WIDTH-1:0] quat_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0] <= QUAT_WIDTH'(1) << FRAC;
         quat_ff[1] <= '0;
         quat_ff[2] <= '0;
         quat_ff[3] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUAT_W: quat_ff[0] <= csr_wdata;
            CSR_QUAT_X: quat_ff[1] <= csr_wdata;
            CSR_QUAT_Y: quat_ff[2] <= csr_wdata;
            CSR_QUAT_Z: quat_ff[3] <= csr_wdata;
            default:    quat_ff[0] <= quat_ff[0];
         endcase
      end
   end

   // stage handshake chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready     = !s4_valid_ff || rsp_if.ready;
   assign s3_ready     = !s3_valid_ff || s4_ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage 1: q times p, twelve products
   logic signed [VEC_WIDTH-1:0] vec_in [3];
   logic signed [PW-1:0]        s1_prod_in [4][3];
   logic signed [PW-1:0]        s1_prod_ff [4][3];
   logic                        s1_last_ff;

   always_comb begin
      vec_in[0] = req_if.in_x;
      vec_in[1] = req_if.in_y;
      vec_in[2] = req_if.in_z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_prod_in[i][j] = PW'(quat_ff[i]) * PW'(vec_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= req_if.in_last;
      end
   end

   // stage 2: sum and round into t, order w x y z
   logic signed [SW1-1:0] s2_sum [4];
   logic signed [SW1-1:0] s2_rnd [4];
   logic signed [TW-1:0]  s2_t_in [4];
   logic signed [TW-1:0]  s2_t_ff [4];
   logic                  s2_last_ff;

   always_comb begin
      s2_sum[0] = -SW1'(s1_prod_ff[1][0]) - SW1'(s1_prod_ff[2][1]) - SW1'(s1_prod_ff[3][2]);
      s2_sum[1] =  SW1'(s1_prod_ff[0][0]) + SW1'(s1_prod_ff[2][2]) - SW1'(s1_prod_ff[3][1]);
      s2_sum[2] =  SW1'(s1_prod_ff[0][1]) - SW1'(s1_prod_ff[1][2]) + SW1'(s1_prod_ff[3][0]);
      s2_sum[3] =  SW1'(s1_prod_ff[0][2]) + SW1'(s1_prod_ff[1][1]) - SW1'(s1_prod_ff[2][0]);
      for (int i = 0; i < 4; i++) begin
         s2_rnd[i]  = (s2_sum[i] + HALF1) >>> FRAC;
         s2_t_in[i] = s2_rnd[i][TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_t_ff    <= s2_t_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 3: t times conj(q), four products per output component
   logic signed [MW-1:0] s3_prod_in [3][4];
   logic signed [MW-1:0] s3_prod_ff [3][4];
   logic                 s3_last_ff;

   always_comb begin
      // x: -tw*x + tx*w - ty*z + tz*y
      s3_prod_in[0][0] = MW'(s2_t_ff[0]) * MW'(quat_ff[1]);
      s3_prod_in[0][1] = MW'(s2_t_ff[1]) * MW'(quat_ff[0]);
      s3_prod_in[0][2] = MW'(s2_t_ff[2]) * MW'(quat_ff[3]);
      s3_prod_in[0][3] = MW'(s2_t_ff[3]) * MW'(quat_ff[2]);
      // y: -tw*y + tx*z + ty*w - tz*x
      s3_prod_in[1][0] = MW'(s2_t_ff[0]) * MW'(quat_ff[2]);
      s3_prod_in[1][1] = MW'(s2_t_ff[1]) * MW'(quat_ff[3]);
      s3_prod_in[1][2] = MW'(s2_t_ff[2]) * MW'(quat_ff[0]);
      s3_prod_in[1][3] = MW'(s2_t_ff[3]) * MW'(quat_ff[1]);
      // z: -tw*z - tx*y + ty*x + tz*w
      s3_prod_in[2][0] = MW'(s2_t_ff[0]) * MW'(quat_ff[3]);
      s3_prod_in[2][1] = MW'(s2_t_ff[1]) * MW'(quat_ff[2]);
      s3_prod_in[2][2] = MW'(s2_t_ff[2]) * MW'(quat_ff[1]);
      s3_prod_in[2][3] = MW'(s2_t_ff[3]) * MW'(quat_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_prod_ff <= s3_prod_in;
         s3_last_ff <= s2_last_ff;
      end
   end

   // stage 4: sum, round, saturate into the output register
   logic signed [SW2-1:0]       s4_sum [3];
   logic signed [SW2-1:0]       s4_rnd [3];
   logic signed [VEC_WIDTH-1:0] s4_res_in [3];
   logic signed [VEC_WIDTH-1:0] s4_res_ff [3];
   logic                        s4_last_ff;

   always_comb begin
      s4_sum[0] = -SW2'(s3_prod_ff[0][0]) + SW2'(s3_prod_ff[0][1])
                  - SW2'(s3_prod_ff[0][2]) + SW2'(s3_prod_ff[0][3]);
      s4_sum[1] = -SW2'(s3_prod_ff[1][0]) + SW2'(s3_prod_ff[1][1])
                  + SW2'(s3_prod_ff[1][2]) - SW2'(s3_prod_ff[1][3]);
      s4_sum[2] = -SW2'(s3_prod_ff[2][0]) - SW2'(s3_prod_ff[2][1])
                  + SW2'(s3_prod_ff[2][2]) + SW2'(s3_prod_ff[2][3]);
      for (int i = 0; i < 3; i++) begin
         s4_rnd[i] = (s4_sum[i] + HALF2) >>> FRAC;
         priority if (s4_rnd[i] > VMAX) begin
            s4_res_in[i] = VMAX[VEC_WIDTH-1:0];
         end else if (s4_rnd[i] < VMIN) begin
            s4_res_in[i] = VMIN[VEC_WIDTH-1:0];
         end else begin
            s4_res_in[i] = s4_rnd[i][VEC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_res_ff  <= s4_res_in;
         s4_last_ff <= s3_last_ff;
      end
   end

   assign rsp_if.valid    = s4_valid_ff;
   assign rsp_if.out_x    = s4_res_ff[0];
   assign rsp_if.out_y    = s4_res_ff[1];
   assign rsp_if.out_z    = s4_res_ff[2];
   assign rsp_if.out_last = s4_last_ff;

endmodule
